FILE: rtl/box_downsample_threshold_bitpack_assert.svh
// Assertion macros for the box downsample threshold bitpack block.
// Included by modules that assert; expects clk and rst_n in scope.
`ifndef BOX_DOWNSAMPLE_THRESHOLD_BITPACK_ASSERT_SVH
`define BOX_DOWNSAMPLE_THRESHOLD_BITPACK_ASSERT_SVH

// condition holds at every clock edge out of reset
`define BDTB_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// same-cycle implication
`define BDTB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BDTB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bdtb_pkg.sv
// Package for the box downsample threshold bitpack block.
// Shared types and fixed constants; no dependencies.
package bdtb_pkg;

    localparam int VALUE_W    = 8;
    localparam int COORD_W    = 13;
    localparam int CNT_W      = 9;
    localparam int SUM_W      = 26;
    localparam int AREA_W     = 2 * CNT_W;
    localparam int FIFO_DEPTH = 8;

    localparam logic [6:0]         DARK_LEVEL = 7'd127;
    localparam logic [VALUE_W-1:0] END_MARK   = 8'hff;

    localparam logic [CNT_W-1:0] CELL_WIDTH_RESET  = 9'd50;
    localparam logic [CNT_W-1:0] CELL_HEIGHT_RESET = 9'd28;

    typedef enum logic [1:0] {
        REG_REGION_LEFT = 2'd0,
        REG_REGION_TOP  = 2'd1,
        REG_CELL_WIDTH  = 2'd2,
        REG_CELL_HEIGHT = 2'd3
    } bdtb_reg_t;

    // broadcast to every cell
    typedef struct packed {
        logic step;
        logic advance;
        logic band_end;
    } bdtb_ctrl_t;

    typedef struct packed {
        logic [VALUE_W-1:0] sprite_byte;
        logic               sprite_done;
        logic               last_of_run;
    } bdtb_out_t;

endpackage

FILE: rtl/bdtb_cell.sv
// One grid column cell: band accumulator, band snapshot and threshold test.
// The column token rotates through the ring of cells. Uses bdtb_pkg.
module bdtb_cell #(
    parameter bit FIRST = 1'b0
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bdtb_pkg::bdtb_ctrl_t           ctrl,
    input  logic [bdtb_pkg::VALUE_W-1:0]   value,
    input  logic                           token_in,
    output logic                           token_out,
    input  logic [bdtb_pkg::SUM_W-1:0]     limit,
    output logic                           dark
);
    import bdtb_pkg::*;

    logic             token_reg;
    logic             token_next;
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    logic [SUM_W-1:0] hold_reg;
    logic [SUM_W-1:0] hold_next;
    logic [SUM_W-1:0] sum_plus;
    logic             hit;

    assign hit      = ctrl.step & token_reg;
    assign sum_plus = sum_reg + SUM_W'(value);

    always_comb
    begin
        sum_next   = sum_reg;
        hold_next  = hold_reg;
        token_next = token_reg;
        if (ctrl.band_end)
        begin
            hold_next = hit ? sum_plus : sum_reg;
            sum_next  = '0;
        end
        else if (hit)
        begin
            sum_next = sum_plus;
        end
        if (ctrl.step && ctrl.advance)
        begin
            token_next = token_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_reg <= FIRST;
            sum_reg   <= '0;
        end
        else
        begin
            token_reg <= token_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

    assign token_out = token_reg;
    assign dark      = hold_reg < limit;

endmodule

FILE: rtl/bdtb_fifo.sv
// Output queue for packed sprite words.
// Register-based circular buffer, power-of-two depth; no package use.
module bdtb_fifo #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    input  logic                       pop,
    output logic                       out_valid,
    output logic [WIDTH-1:0]           out_data,
    output logic [$clog2(DEPTH+1)-1:0] level
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int LVL_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [LVL_W-1:0] count_reg;
    logic [LVL_W-1:0] count_next;
    logic             do_pop;

    assign do_pop = pop & (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + LVL_W'(push) - LVL_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign out_valid = count_reg != '0;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign level     = count_reg;

endmodule

FILE: rtl/box_downsample_threshold_bitpack.sv
// Top level: box downsample, binary threshold and bit packing of a pixel stream.
// Uses bdtb_pkg, bdtb_cell, bdtb_fifo and the assertion header.
//
//  channel   dir  handshake             payload
//  s_axis    in   tvalid/tready         tdata: pix_level, pixel_col, pixel_row
//  m_axis    out  tvalid/tready         tdata: sprite_byte; tuser: sprite_done;
//                                       tlast: last_of_run
//  cfg       in   cfg_we                cfg_addr, cfg_wdata
//
// One pixel word per cycle while tready is high. A band's completing pixel is staged,
// then loaded into the serializer, which puts its bytes into the output queue one byte
// per cycle. s_axis_tready drops while queued plus pending bytes exceed the queue depth
// less the largest burst. Reset is asynchronous and clears the running sums and counters.
`include "box_downsample_threshold_bitpack_assert.svh"

module box_downsample_threshold_bitpack #(
    parameter int GRID_COLUMNS = 24,
    parameter int GRID_ROWS    = 21,
    parameter int COORD_LIMIT  = 8192
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // pix_level[7:0], pixel_col[20:8], pixel_row[33:21]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // sprite_byte[7:0]
    output logic        m_axis_tuser,   // sprite_done[0]
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [12:0] cfg_wdata
);
    import bdtb_pkg::*;

    localparam int BAND_BYTES = (GRID_COLUMNS + 7) / 8;
    localparam int BITS_W     = BAND_BYTES * 8;
    localparam int MAX_BURST  = BAND_BYTES + 1;
    localparam int SER_W      = $clog2(MAX_BURST + 1);
    localparam int OCC_W      = $clog2(FIFO_DEPTH + 1);
    localparam int COLS_W     = $clog2(GRID_COLUMNS + 1);
    localparam int ROWS_W     = $clog2(GRID_ROWS + 1);
    localparam int SPAN_X_W   = CNT_W + COLS_W;
    localparam int SPAN_Y_W   = CNT_W + ROWS_W;
    localparam int RIGHT_W    = ((SPAN_X_W > COORD_W) ? SPAN_X_W : COORD_W) + 1;
    localparam int BOTTOM_W   = ((SPAN_Y_W > COORD_W) ? SPAN_Y_W : COORD_W) + 1;
    localparam int LIM_W      = $clog2(COORD_LIMIT + 1);
    localparam int CMP_W      = (LIM_W > COORD_W) ? LIM_W : COORD_W;
    localparam int BAND_W     = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int OUT_W      = $bits(bdtb_out_t);

    // configuration
    logic [COORD_W-1:0] region_left_reg;
    logic [COORD_W-1:0] region_top_reg;
    logic [CNT_W-1:0]   cell_width_reg;
    logic [CNT_W-1:0]   cell_height_reg;
    logic [AREA_W-1:0]  area_reg;
    logic [SUM_W-1:0]   limit;

    // raster counters
    logic [CNT_W-1:0]   x_reg;
    logic [CNT_W-1:0]   x_next;
    logic [CNT_W-1:0]   y_reg;
    logic [CNT_W-1:0]   y_next;
    logic [BAND_W-1:0]  band_reg;
    logic [BAND_W-1:0]  band_next;

    logic [VALUE_W-1:0] pix_level;
    logic [COORD_W-1:0] pixel_col;
    logic [COORD_W-1:0] pixel_row;
    logic [SPAN_X_W-1:0] span_x;
    logic [SPAN_Y_W-1:0] span_y;
    logic [RIGHT_W-1:0]  right_edge;
    logic [BOTTOM_W-1:0] bottom_edge;
    logic                in_region;
    logic                accept;
    logic [CNT_W-1:0]    x_inc;
    logic [CNT_W-1:0]    y_inc;
    logic                advance;
    logic                row_end;
    logic                band_done;
    logic                sprite_end;
    bdtb_ctrl_t          ctrl;

    logic [GRID_COLUMNS-1:0] tok_vec;
    logic [GRID_COLUMNS-1:0] dark_vec;
    logic [BITS_W-1:0]       packed_bits;

    // band serializer
    logic               pend_reg;
    logic               pend_term_reg;
    logic [BITS_W-1:0]  ser_bits_reg;
    logic [BITS_W-1:0]  ser_bits_next;
    logic [SER_W-1:0]   ser_cnt_reg;
    logic [SER_W-1:0]   ser_cnt_next;
    logic               ser_term_reg;
    logic               push;
    logic               band_byte;
    bdtb_out_t          push_data;

    // output queue credit
    logic [OCC_W-1:0]   occ_reg;
    logic [OCC_W-1:0]   occ_next;
    logic [OCC_W-1:0]   burst;
    logic               pop;
    logic [OCC_W-1:0]   fifo_level;
    logic [OUT_W-1:0]   fifo_out;
    bdtb_out_t          out_word;

    assign pix_level = s_axis_tdata[7:0];
    assign pixel_col = s_axis_tdata[20:8];
    assign pixel_row = s_axis_tdata[33:21];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_left_reg <= '0;
            region_top_reg  <= '0;
            cell_width_reg  <= CELL_WIDTH_RESET;
            cell_height_reg <= CELL_HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_REGION_LEFT: region_left_reg <= cfg_wdata;
                REG_REGION_TOP:  region_top_reg  <= cfg_wdata;
                REG_CELL_WIDTH:  cell_width_reg  <= cfg_wdata[CNT_W-1:0];
                REG_CELL_HEIGHT: cell_height_reg <= cfg_wdata[CNT_W-1:0];
                default:         ;
            endcase
        end
    end

    // area is registered from the cell size registers; the compare snapshot is loaded
    // in the cycle after the band-ending pixel is accepted
    always_ff @(posedge clk)
    begin
        area_reg <= AREA_W'(cell_width_reg) * AREA_W'(cell_height_reg);
    end

    assign limit = (SUM_W'(area_reg) << 7) - SUM_W'(area_reg);

    always_comb
    begin
        span_x      = SPAN_X_W'(cell_width_reg) * SPAN_X_W'(GRID_COLUMNS);
        span_y      = SPAN_Y_W'(cell_height_reg) * SPAN_Y_W'(GRID_ROWS);
        right_edge  = RIGHT_W'(region_left_reg) + RIGHT_W'(span_x);
        bottom_edge = BOTTOM_W'(region_top_reg) + BOTTOM_W'(span_y);
        in_region   = (CMP_W'(pixel_col) < CMP_W'(COORD_LIMIT))
                    && (CMP_W'(pixel_row) < CMP_W'(COORD_LIMIT))
                    && (pixel_col >= region_left_reg)
                    && (RIGHT_W'(pixel_col) < right_edge)
                    && (pixel_row >= region_top_reg)
                    && (BOTTOM_W'(pixel_row) < bottom_edge);
    end

    assign accept = s_axis_tvalid & s_axis_tready;

    always_comb
    begin
        x_inc      = x_reg + 1'b1;
        y_inc      = y_reg + 1'b1;
        advance    = x_inc >= cell_width_reg;
        row_end    = advance & tok_vec[GRID_COLUMNS-1];
        band_done  = row_end & (y_inc >= cell_height_reg);
        sprite_end = band_done & (band_reg == BAND_W'(GRID_ROWS - 1));

        ctrl.step     = accept & in_region;
        ctrl.advance  = advance;
        ctrl.band_end = ctrl.step & band_done;

        x_next    = x_reg;
        y_next    = y_reg;
        band_next = band_reg;
        if (ctrl.step)
        begin
            x_next = advance ? '0 : x_inc;
            if (row_end)
            begin
                y_next = band_done ? '0 : y_inc;
            end
            if (band_done)
            begin
                band_next = sprite_end ? '0 : band_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg    <= '0;
            y_reg    <= '0;
            band_reg <= '0;
        end
        else
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            band_reg <= band_next;
        end
    end

    genvar g;
    generate
        for (g = 0; g < GRID_COLUMNS; g++)
        begin : g_cell
            bdtb_cell #(
                .FIRST (1'(g == 0))
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .value     (pix_level),
                .token_in  (tok_vec[(g + GRID_COLUMNS - 1) % GRID_COLUMNS]),
                .token_out (tok_vec[g]),
                .limit     (limit),
                .dark      (dark_vec[g])
            );
        end
    endgenerate

    // first cell lands in the highest used bit
    always_comb
    begin
        packed_bits = '0;
        for (int c = 0; c < GRID_COLUMNS; c++)
        begin
            packed_bits[GRID_COLUMNS-1-c] = dark_vec[c];
        end
    end

    always_comb
    begin
        push      = ser_cnt_reg != '0;
        band_byte = !(ser_term_reg && (ser_cnt_reg == SER_W'(1)));
        push_data.sprite_byte = band_byte ? ser_bits_reg[BITS_W-1 -: 8] : END_MARK;
        push_data.sprite_done = !band_byte;
        push_data.last_of_run = ser_cnt_reg == SER_W'(1);

        ser_bits_next = ser_bits_reg;
        ser_cnt_next  = ser_cnt_reg;
        if (pend_reg)
        begin
            ser_bits_next = packed_bits;
            ser_cnt_next  = SER_W'(BAND_BYTES) + SER_W'(pend_term_reg);
        end
        else if (push)
        begin
            ser_cnt_next = ser_cnt_reg - 1'b1;
            if (band_byte)
            begin
                ser_bits_next = ser_bits_reg << 8;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            pend_term_reg <= 1'b0;
            ser_cnt_reg   <= '0;
            ser_term_reg  <= 1'b0;
        end
        else
        begin
            pend_reg    <= ctrl.band_end;
            ser_cnt_reg <= ser_cnt_next;
            if (ctrl.band_end)
            begin
                pend_term_reg <= sprite_end;
            end
            if (pend_reg)
            begin
                ser_term_reg <= pend_term_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ser_bits_reg <= ser_bits_next;
    end

    // credit counts queued bytes plus bytes promised by accepted band ends
    always_comb
    begin
        pop      = m_axis_tvalid & m_axis_tready;
        burst    = ctrl.band_end ? OCC_W'(BAND_BYTES) + OCC_W'(sprite_end) : '0;
        occ_next = occ_reg + burst - OCC_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    assign s_axis_tready = occ_reg <= OCC_W'(FIFO_DEPTH - MAX_BURST);

    bdtb_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_data  (fifo_out),
        .level     (fifo_level)
    );

    assign out_word     = bdtb_out_t'(fifo_out);
    assign m_axis_tdata = out_word.sprite_byte;
    assign m_axis_tuser = out_word.sprite_done;
    assign m_axis_tlast = out_word.last_of_run;

    `BDTB_ASSERT(a_token_onehot, $onehot(tok_vec), "column token lost or duplicated")
    `BDTB_ASSERT(a_credit_covers_queue, occ_reg >= fifo_level, "queue credit below fill")
    `BDTB_ASSERT_IMP(a_no_load_while_busy, pend_reg, ser_cnt_reg == '0, "band load overlaps burst")
    `BDTB_ASSERT_NEXT(a_band_end_loads, ctrl.band_end, pend_reg, "band end not staged")
    `BDTB_ASSERT_IMP(a_done_is_last, push && push_data.sprite_done, push_data.last_of_run, "terminator not last")

endmodule
